@@ design/mqrf_pkg.sv @@
// Shared payload types and operation/status codes for the multi-queue ring FIFO.
package mqrf_pkg;

   localparam int WORD_WIDTH   = 32;
   localparam int MODE_WIDTH   = 2;
   localparam int QIDX_WIDTH   = 3;
   localparam int STATUS_WIDTH = 2;
   localparam int OCC_WIDTH    = 5;

   localparam logic [MODE_WIDTH-1:0] MODE_INIT  = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_WRITE = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_REJECT = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL   = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY  = 2'd3;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]        mode;
      logic [QIDX_WIDTH-1:0]        queue_index;
      logic signed [WORD_WIDTH-1:0] write_word;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]      status;
      logic signed [WORD_WIDTH-1:0] read_word;
      logic [WORD_WIDTH-1:0]        lost_words;
      logic [OCC_WIDTH-1:0]         occupancy;
   } rsp_payload_type;

endpackage

@@ design/mqrf_chan_if.sv @@
// Valid/ready channel interface carrying one payload item.
interface mqrf_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ design/mqrf_word_ram.sv @@
// Word store RAM: one write port, one read port, registered read data.
module mqrf_word_ram
   import mqrf_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int ADDR_WIDTH = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WORD_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WORD_WIDTH-1:0] rd_data
);

   logic [WORD_WIDTH-1:0] mem [DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/multi_queue_ring_fifo_top.sv @@
// Top level of the multi-queue ring FIFO: descriptor memory, sequencer and word store.
//
//  channel   dir  handshake            payload
//  req_chan  in   valid/ready          mode, queue_index, write_word
//  rsp_chan  out  valid/ready          status, read_word, lost_words, occupancy
//
// One item at a time: accept (idle), descriptor read-modify-write, word read and
// result load. The descriptor read is registered at accept, and the word store
// read data is registered before the result load.
// A result waiting in the output register does not block the next accept; a
// second result stalls in the final step until rsp_chan.ready frees the register.
// Synchronous active-high reset clears the state, the output valid and the
// descriptor valid bits; queues then read as empty with zero pointers.
module multi_queue_ring_fifo_top
   import mqrf_pkg::*;
#(
   parameter int NUM_QUEUES  = 4,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   mqrf_chan_if.sink   req_chan,
   mqrf_chan_if.source rsp_chan
);

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SD = NUM_QUEUES * QUEUE_DEPTH;
   localparam int AW = $clog2(SD);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DESC = 2'd1;
   localparam logic [1:0] S_DATA = 2'd2;

   // per-queue descriptor
   typedef struct packed {
      logic [PW-1:0]         head;
      logic [PW-1:0]         tail;
      logic [CW-1:0]         count;
      logic [WORD_WIDTH-1:0] lost;
   } desc_type;

   logic [1:0] state_ff, state_in;

   // latched request
   logic [MODE_WIDTH-1:0] mode_ff;
   logic [QIDX_WIDTH-1:0] qidx_ff;
   logic [WORD_WIDTH-1:0] word_ff;

   // descriptor memory; valid bits make unwritten entries read as zero
   desc_type        desc_mem [NUM_QUEUES];
   desc_type        desc_rd_ff;
   logic            desc_hit_ff;
   logic [NUM_QUEUES-1:0] desc_valid_ff;

   // result staging between descriptor step and output load
   logic [STATUS_WIDTH-1:0] stat_ff, stat_in;
   logic [WORD_WIDTH-1:0]   lost_ff, lost_in;
   logic [OCC_WIDTH-1:0]    occ_ff, occ_in;
   logic                    rdok_ff, rdok_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff;

   logic            req_fire;
   logic [QW-1:0]   req_q;
   logic [QW-1:0]   cur_q;
   logic            bad_q;
   desc_type        cur, nxt;
   logic            desc_we;
   logic            st_wr_en, st_rd_en;
   logic [AW-1:0]   st_base, st_addr;
   logic [PW-1:0]   ptr_sel;
   logic [WORD_WIDTH-1:0] st_rd_data;
   logic [CW+OCC_WIDTH-1:0] occ_ext;
   logic            out_free;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_q          = req_chan.payload.queue_index[QW-1:0];
   assign cur_q          = qidx_ff[QW-1:0];
   assign bad_q          = ({1'b0, qidx_ff} >= 4'(NUM_QUEUES));
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // request latch and descriptor read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff     <= req_chan.payload.mode;
         qidx_ff     <= req_chan.payload.queue_index;
         word_ff     <= req_chan.payload.write_word;
         desc_rd_ff  <= desc_mem[req_q];
         desc_hit_ff <= desc_valid_ff[req_q];
      end
      if (desc_we) begin
         desc_mem[cur_q] <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= '0;
      end else if (desc_we) begin
         desc_valid_ff[cur_q] <= 1'b1;
      end
   end

   // descriptor update: at most one read-modify-write per item (none for a bad index)
   always_comb begin
      cur      = desc_hit_ff ? desc_rd_ff : '0;
      nxt      = cur;
      stat_in  = STATUS_OK;
      rdok_in  = 1'b0;
      st_wr_en = 1'b0;
      st_rd_en = 1'b0;
      ptr_sel  = cur.head;
      if (bad_q) begin
         stat_in = STATUS_REJECT;
      end else begin
         unique case (mode_ff)
            MODE_INIT: begin
               nxt = '0;
            end
            MODE_READ: begin
               if (cur.count == '0) begin
                  stat_in = STATUS_EMPTY;
               end else begin
                  st_rd_en  = (state_ff == S_DESC);
                  rdok_in   = 1'b1;
                  nxt.head  = (cur.head == PW'(QUEUE_DEPTH - 1)) ? '0 : cur.head + 1'b1;
                  nxt.count = cur.count - 1'b1;
               end
            end
            MODE_WRITE: begin
               ptr_sel = cur.tail;
               if (cur.count == CW'(QUEUE_DEPTH)) begin
                  stat_in  = STATUS_FULL;
                  nxt.lost = cur.lost + 1'b1;
               end else begin
                  st_wr_en  = (state_ff == S_DESC);
                  nxt.tail  = (cur.tail == PW'(QUEUE_DEPTH - 1)) ? '0 : cur.tail + 1'b1;
                  nxt.count = cur.count + 1'b1;
               end
            end
            default: begin
               stat_in = STATUS_REJECT;
            end
         endcase
      end
      // queue base is a constant multiple of the index
      st_base = AW'(qidx_ff) * AW'(QUEUE_DEPTH);
      st_addr = st_base + AW'(ptr_sel);
      desc_we = (state_ff == S_DESC) && !bad_q;
      occ_ext = {{OCC_WIDTH{1'b0}}, nxt.count};
      lost_in = bad_q ? '0 : nxt.lost;
      occ_in  = bad_q ? '0 : occ_ext[OCC_WIDTH-1:0];
   end

   mqrf_word_ram #(
      .DEPTH      (SD),
      .ADDR_WIDTH (AW)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_addr),
      .wr_data (word_ff),
      .rd_en   (st_rd_en),
      .rd_addr (st_addr),
      .rd_data (st_rd_data)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_DESC) begin
         stat_ff <= stat_in;
         lost_ff <= lost_in;
         occ_ff  <= occ_in;
         rdok_ff <= rdok_in;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_DESC;
            end
         end
         S_DESC: begin
            state_in = S_DATA;
         end
         S_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register load; read data is zero unless a word was taken
   always_ff @(posedge clock) begin
      if (state_ff == S_DATA && out_free) begin
         rsp_ff.status     <= stat_ff;
         rsp_ff.read_word  <= rdok_ff ? st_rd_data : '0;
         rsp_ff.lost_words <= lost_ff;
         rsp_ff.occupancy  <= occ_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

@@ tb/multi_queue_ring_fifo_top_test.sv @@
// Self-checking bench for the multi-queue ring FIFO: random valid/ready traffic, scoreboarded.
module multi_queue_ring_fifo_top_test;
   import mqrf_pkg::*;

   localparam int NUM_QUEUES  = 4;
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);

   // Mode 3 has no meaning; the block must reject it with the same status as a bad index.
   localparam logic [MODE_WIDTH-1:0] MODE_UNDEF = 2'd3;

   // Cycles without any handshake before the run is declared hung. The longest
   // legal quiet stretch is set by the forced receiver hold below.
   localparam int HANG_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int MAX_PRINTS   = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mqrf_chan_if #(.payload_type(req_payload_type)) req_chan ();
   mqrf_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   multi_queue_ring_fifo_top #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the queue bank, updated once per accepted item.
   // ---------------------------------------------------------------------
   logic signed [WORD_WIDTH-1:0] shadow_words [NUM_QUEUES][QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]         shadow_head  [NUM_QUEUES];
   logic [PTR_WIDTH-1:0]         shadow_tail  [NUM_QUEUES];
   logic [OCC_WIDTH-1:0]         shadow_fill  [NUM_QUEUES];
   logic [WORD_WIDTH-1:0]        shadow_lost  [NUM_QUEUES];

   req_payload_type pending_reqs[$];   // items waiting to be offered
   rsp_payload_type predicted_rsps[$]; // replies owed by the block, oldest first

   int sender_idle_pct = 0;
   int recv_idle_pct   = 0;
   int items_offered   = 0;
   int items_accepted  = 0;
   int rsps_checked    = 0;
   int error_count     = 0;
   int quiet_cycles    = 0;
   int stall_requests  = 0;
   int stall_grants    = 0;
   int hold_left       = 0;
   int full_drops      = 0;
   int empty_reads     = 0;
   int rejects         = 0;

   // Pointer step with wrap at the queue depth.
   function automatic logic [PTR_WIDTH-1:0] next_slot(logic [PTR_WIDTH-1:0] p);
      return (p == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Apply one operation to the shadow bank and return the reply it must produce.
   function automatic rsp_payload_type apply_queue_op(req_payload_type r);
      rsp_payload_type res;
      int unsigned     q;
      res = '0;
      q   = 32'(r.queue_index);
      if (q >= NUM_QUEUES) begin
         // bad index: nothing touched, all-zero reply apart from status
         res.status = STATUS_REJECT;
      end else begin
         res.status = STATUS_OK;
         case (r.mode)
            MODE_INIT: begin
               // any stored data is simply discarded
               shadow_head[q] = '0;
               shadow_tail[q] = '0;
               shadow_fill[q] = '0;
               shadow_lost[q] = '0;
            end
            MODE_READ: begin
               if (shadow_fill[q] == 0) begin
                  res.status = STATUS_EMPTY;
               end else begin
                  res.read_word  = shadow_words[q][shadow_head[q]];
                  shadow_head[q] = next_slot(shadow_head[q]);
                  shadow_fill[q] = shadow_fill[q] - 1'b1;
               end
            end
            MODE_WRITE: begin
               if (shadow_fill[q] >= QUEUE_DEPTH) begin
                  // dropped word; lost count wraps naturally at 32 bits
                  shadow_lost[q] = shadow_lost[q] + 1'b1;
                  res.status     = STATUS_FULL;
               end else begin
                  shadow_words[q][shadow_tail[q]] = r.write_word;
                  shadow_tail[q] = next_slot(shadow_tail[q]);
                  shadow_fill[q] = shadow_fill[q] + 1'b1;
               end
            end
            default: res.status = STATUS_REJECT; // undefined mode, valid queue
         endcase
         res.lost_words = shadow_lost[q];
         res.occupancy  = shadow_fill[q];
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (error_count < MAX_PRINTS)
         $display("MISMATCH reply %0d %s: got 0x%0h expected 0x%0h",
                  rsps_checked, what, got, want);
      error_count++;
   endtask

   task automatic add_req(logic [MODE_WIDTH-1:0] m, logic [QIDX_WIDTH-1:0] q,
                          logic [WORD_WIDTH-1:0] w);
      req_payload_type r;
      r.mode        = m;
      r.queue_index = q;
      r.write_word  = w;
      pending_reqs.push_back(r);
   endtask

   // Bias data toward the sign boundaries and all-zero/all-one patterns.
   function automatic logic [WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // One random run of traffic. Mostly well-formed bursts on a single queue so
   // that queues actually reach full and empty; some init and raw noise mixed in.
   task automatic add_random_burst();
      int unsigned q;
      int unsigned len;
      int unsigned kind;
      q    = $urandom_range(NUM_QUEUES - 1);
      len  = $urandom_range(20, 1);
      kind = $urandom_range(9);
      if (kind <= 3) begin
         repeat (len) add_req(MODE_WRITE, QIDX_WIDTH'(q), pick_word());
      end else if (kind <= 6) begin
         repeat (len) add_req(MODE_READ, QIDX_WIDTH'(q), $urandom);
      end else if (kind == 7) begin
         add_req(MODE_INIT, QIDX_WIDTH'(q), $urandom);
      end else begin
         // noise: any mode, any index, including undefined mode and bad queues
         repeat ($urandom_range(4, 1))
            add_req(MODE_WIDTH'($urandom_range(3)), QIDX_WIDTH'($urandom_range(7)),
                    pick_word());
      end
   endtask

   task automatic add_random_items(int target);
      int start_size;
      start_size = pending_reqs.size();
      while (pending_reqs.size() - start_size < target) add_random_burst();
   endtask

   // Block until every queued item has gone in and every reply has come back.
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || items_accepted != items_offered ||
             predicted_rsps.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: changes on the falling edge, holds an item until taken.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (items_accepted == items_offered) begin
         // nothing outstanding: offer the next item or idle this cycle
         if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_chan.payload <= pending_reqs.pop_front();
            req_chan.valid   <= 1'b1;
            items_offered++;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Reply acceptor: random backpressure plus a single long hold, asked for by
   // the stimulus, that lets the block fill up and push back on its input.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_grants != stall_requests) begin
         stall_grants++;
         hold_left = HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor and scoreboard, sampled on the rising edge. The reply side is
   // checked before the request side is predicted so a same-edge request can
   // never be matched against its own reply.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_chan.valid && rsp_chan.ready) begin
            quiet_cycles = 0;
            got = rsp_chan.payload;
            if (predicted_rsps.size() == 0) begin
               report_mismatch("unexpected item", 64'(got.status), '0);
            end else begin
               want = predicted_rsps.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
               if (got.read_word !== want.read_word)
                  report_mismatch("read_word", 64'(got.read_word), 64'(want.read_word));
               if (got.lost_words !== want.lost_words)
                  report_mismatch("lost_words", 64'(got.lost_words),
                                  64'(want.lost_words));
               if (got.occupancy !== want.occupancy)
                  report_mismatch("occupancy", 64'(got.occupancy), 64'(want.occupancy));
               case (want.status)
                  STATUS_FULL:   full_drops++;
                  STATUS_EMPTY:  empty_reads++;
                  STATUS_REJECT: rejects++;
                  default: ;
               endcase
            end
            rsps_checked++;
         end
         if (req_chan.valid && req_chan.ready) begin
            quiet_cycles = 0;
            predicted_rsps.push_back(apply_queue_op(req_chan.payload));
            items_accepted++;
         end
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("Hang: no handshake for %0d cycles, %0d replies owed",
                     HANG_LIMIT, predicted_rsps.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus sequence
   // ---------------------------------------------------------------------
   initial begin
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         shadow_head[q] = '0;
         shadow_tail[q] = '0;
         shadow_fill[q] = '0;
         shadow_lost[q] = '0;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: sign extremes through one queue, empty read, init on a fresh
      // queue and on one holding data, bad indices for every mode, undefined mode.
      add_req(MODE_WRITE, 0, 32'h7FFF_FFFF);
      add_req(MODE_WRITE, 0, 32'h8000_0000);
      add_req(MODE_WRITE, 0, 32'hFFFF_FFFF);
      add_req(MODE_WRITE, 0, 32'h0000_0000);
      repeat (4) add_req(MODE_READ, 0, '0);
      add_req(MODE_READ, 0, '1);             // empty read
      add_req(MODE_INIT, 1, '0);             // init of an empty queue
      add_req(MODE_WRITE, 2, 32'h5A5A_A5A5);
      add_req(MODE_WRITE, 2, 32'hA5A5_5A5A);
      add_req(MODE_INIT, 2, '0);             // data thrown away
      add_req(MODE_READ, 2, '0);             // now empty again
      add_req(MODE_WRITE, 3, 32'h1234_5678);
      add_req(MODE_READ, 3, '0);
      add_req(MODE_READ, 4, '0);             // bad index, each mode
      add_req(MODE_WRITE, 7, 32'h0000_0001);
      add_req(MODE_INIT, 5, '0);
      add_req(MODE_UNDEF, 6, '1);            // undefined mode and bad index
      add_req(MODE_UNDEF, 0, '1);            // undefined mode, good queue
      add_req(MODE_UNDEF, 3, '0);
      wait_drained();

      // Random phase one: sender mostly busy, receiver stalls often.
      sender_idle_pct = 18;
      recv_idle_pct   = 59;
      add_random_items(275);
      wait_drained();

      // Random phase two: the other way round.
      sender_idle_pct = 59;
      recv_idle_pct   = 18;
      add_random_items(275);
      wait_drained();

      // Random phase three: no idling, opening with a long receiver hold while
      // items keep coming so the input side backs up.
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
      stall_requests++;
      add_random_items(275);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items across %0d queues: %0d full drops, %0d empty reads,",
               items_accepted, NUM_QUEUES, full_drops, empty_reads);
      $display("%0d rejects, %0d replies checked, %0d mismatches",
               rejects, rsps_checked, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/mqrf_pkg.sv
design/mqrf_chan_if.sv
design/mqrf_word_ram.sv
design/multi_queue_ring_fifo_top.sv
tb/multi_queue_ring_fifo_top_test.sv
